### hdl/ipv4f_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 filter package
// Shared types, protocol numbers, enable bit positions and register indexes.
// ----------------------------------------------------------------------------
package ipv4f_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH  = 32;
   localparam int unsigned COUNT_WIDTH     = 32;

   // protocol numbers
   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_IGMP = 8'd2;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;

   // enable mask bit positions
   localparam int unsigned EN_SRC_ADDR   = 0;
   localparam int unsigned EN_DST_ADDR   = 1;
   localparam int unsigned EN_SRC_PORT   = 2;
   localparam int unsigned EN_DST_PORT   = 3;
   localparam int unsigned EN_TTL_MIN    = 4;
   localparam int unsigned EN_TTL_MAX    = 5;
   localparam int unsigned EN_FRAG_MIN   = 6;
   localparam int unsigned EN_FRAG_MAX   = 7;
   localparam int unsigned EN_PROTO      = 8;
   localparam int unsigned EN_ALLOW_TCP  = 9;
   localparam int unsigned EN_ALLOW_UDP  = 10;
   localparam int unsigned EN_ALLOW_ICMP = 11;
   localparam int unsigned EN_ALLOW_IGMP = 12;

   localparam logic [15:0] TTL_WINDOW_RESET = 16'hFF00;
   localparam logic [15:0] FRAG_HIGH_RESET  = 16'hFFFF;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ENABLE_MASK     = 4'd0,
      CSR_SRC_ADDR_MATCH  = 4'd1,
      CSR_DST_ADDR_MATCH  = 4'd2,
      CSR_SRC_PORT_MATCH  = 4'd3,
      CSR_DST_PORT_MATCH  = 4'd4,
      CSR_TTL_WINDOW      = 4'd5,
      CSR_FRAG_LOW_BOUND  = 4'd6,
      CSR_FRAG_HIGH_BOUND = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [12:0] enable_mask;
      logic [31:0] src_addr_match;
      logic [31:0] dst_addr_match;
      logic [15:0] src_port_match;
      logic [15:0] dst_port_match;
      logic [15:0] ttl_window;
      logic [15:0] frag_low_bound;
      logic [15:0] frag_high_bound;
   } cfg_type;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [7:0]  time_to_live;
      logic [15:0] frag_word;
      logic [7:0]  protocol;
      logic [15:0] src_port;
      logic [15:0] dst_port;
   } hdr_type;

   // per-packet decision: which counters step and whether the total steps
   typedef struct packed {
      logic accept;
      logic bump_tcp;
      logic bump_udp;
      logic bump_icmp;
      logic bump_igmp;
      logic bump_other;
   } verdict_type;

   typedef struct packed {
      logic                   accepted;
      logic [COUNT_WIDTH-1:0] tcp_count;
      logic [COUNT_WIDTH-1:0] udp_count;
      logic [COUNT_WIDTH-1:0] icmp_count;
      logic [COUNT_WIDTH-1:0] igmp_count;
      logic [COUNT_WIDTH-1:0] other_count;
      logic [COUNT_WIDTH-1:0] total_count;
   } result_type;

endpackage

### hdl/ipv4f_csr.sv
// ----------------------------------------------------------------------------
// IPv4 filter configuration registers
// Holds the eight filter registers written through the configuration port.
// ----------------------------------------------------------------------------
module ipv4f_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  wr_en,
   input  logic [ipv4f_pkg::CSR_INDEX_WIDTH-1:0] wr_index,
   input  logic [ipv4f_pkg::CSR_DATA_WIDTH-1:0]  wr_data,
   output ipv4f_pkg::cfg_type                    cfg
);

   ipv4f_pkg::cfg_type cfg_ff;
   ipv4f_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (ipv4f_pkg::csr_index_type'(wr_index))
            ipv4f_pkg::CSR_ENABLE_MASK:     cfg_in.enable_mask     = wr_data[12:0];
            ipv4f_pkg::CSR_SRC_ADDR_MATCH:  cfg_in.src_addr_match  = wr_data[31:0];
            ipv4f_pkg::CSR_DST_ADDR_MATCH:  cfg_in.dst_addr_match  = wr_data[31:0];
            ipv4f_pkg::CSR_SRC_PORT_MATCH:  cfg_in.src_port_match  = wr_data[15:0];
            ipv4f_pkg::CSR_DST_PORT_MATCH:  cfg_in.dst_port_match  = wr_data[15:0];
            ipv4f_pkg::CSR_TTL_WINDOW:      cfg_in.ttl_window      = wr_data[15:0];
            ipv4f_pkg::CSR_FRAG_LOW_BOUND:  cfg_in.frag_low_bound  = wr_data[15:0];
            ipv4f_pkg::CSR_FRAG_HIGH_BOUND: cfg_in.frag_high_bound = wr_data[15:0];
            default: ; // drop writes to unused indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_mask     <= '0;
         cfg_ff.src_addr_match  <= '0;
         cfg_ff.dst_addr_match  <= '0;
         cfg_ff.src_port_match  <= '0;
         cfg_ff.dst_port_match  <= '0;
         cfg_ff.ttl_window      <= ipv4f_pkg::TTL_WINDOW_RESET;
         cfg_ff.frag_low_bound  <= '0;
         cfg_ff.frag_high_bound <= ipv4f_pkg::FRAG_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/ipv4f_check.sv
// ----------------------------------------------------------------------------
// IPv4 filter decision logic
// Applies the enabled header, protocol and port checks to one header.
// ----------------------------------------------------------------------------
module ipv4f_check (
   input  ipv4f_pkg::hdr_type     hdr,
   input  ipv4f_pkg::cfg_type     cfg,
   output ipv4f_pkg::verdict_type verdict
);

   logic [12:0] en;
   logic        hdr_ok;
   logic        port_ok;
   logic        is_tcp;
   logic        is_udp;
   logic        is_icmp;
   logic        is_igmp;
   logic        is_other;

   assign en = cfg.enable_mask;

   assign hdr_ok =
      (!en[ipv4f_pkg::EN_SRC_ADDR] || (hdr.src_addr == cfg.src_addr_match)) &&
      (!en[ipv4f_pkg::EN_DST_ADDR] || (hdr.dst_addr == cfg.dst_addr_match)) &&
      (!en[ipv4f_pkg::EN_TTL_MIN]  || (hdr.time_to_live >= cfg.ttl_window[7:0])) &&
      (!en[ipv4f_pkg::EN_TTL_MAX]  || (hdr.time_to_live <= cfg.ttl_window[15:8])) &&
      (!en[ipv4f_pkg::EN_FRAG_MIN] || (hdr.frag_word >= cfg.frag_low_bound)) &&
      (!en[ipv4f_pkg::EN_FRAG_MAX] || (hdr.frag_word <= cfg.frag_high_bound));

   assign port_ok =
      (!en[ipv4f_pkg::EN_SRC_PORT] || (hdr.src_port == cfg.src_port_match)) &&
      (!en[ipv4f_pkg::EN_DST_PORT] || (hdr.dst_port == cfg.dst_port_match));

   assign is_tcp   = (hdr.protocol == ipv4f_pkg::PROTO_TCP);
   assign is_udp   = (hdr.protocol == ipv4f_pkg::PROTO_UDP);
   assign is_icmp  = (hdr.protocol == ipv4f_pkg::PROTO_ICMP);
   assign is_igmp  = (hdr.protocol == ipv4f_pkg::PROTO_IGMP);
   assign is_other = !(is_tcp || is_udp || is_icmp || is_igmp);

   // a protocol counter steps once the header and protocol stages pass
   always_comb begin
      verdict.bump_tcp   = hdr_ok && is_tcp &&
                           (!en[ipv4f_pkg::EN_PROTO] || en[ipv4f_pkg::EN_ALLOW_TCP]);
      verdict.bump_udp   = hdr_ok && is_udp &&
                           (!en[ipv4f_pkg::EN_PROTO] || en[ipv4f_pkg::EN_ALLOW_UDP]);
      verdict.bump_icmp  = hdr_ok && is_icmp &&
                           (!en[ipv4f_pkg::EN_PROTO] || en[ipv4f_pkg::EN_ALLOW_ICMP]);
      verdict.bump_igmp  = hdr_ok && is_igmp &&
                           (!en[ipv4f_pkg::EN_PROTO] || en[ipv4f_pkg::EN_ALLOW_IGMP]);
      verdict.bump_other = hdr_ok && is_other && !en[ipv4f_pkg::EN_PROTO];
      // TCP and UDP must also clear the port stage to reach the total
      verdict.accept = verdict.bump_icmp || verdict.bump_igmp || verdict.bump_other ||
                       ((verdict.bump_tcp || verdict.bump_udp) && port_ok);
   end

endmodule

### hdl/ipv4f_count.sv
// ----------------------------------------------------------------------------
// IPv4 filter counters and result register
// Steps the protocol and total tallies and holds the result of one item.
// ----------------------------------------------------------------------------
module ipv4f_count (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  ipv4f_pkg::verdict_type verdict,
   output ipv4f_pkg::result_type  result
);

   logic [ipv4f_pkg::COUNT_WIDTH-1:0] tcp_ff,   tcp_in;
   logic [ipv4f_pkg::COUNT_WIDTH-1:0] udp_ff,   udp_in;
   logic [ipv4f_pkg::COUNT_WIDTH-1:0] icmp_ff,  icmp_in;
   logic [ipv4f_pkg::COUNT_WIDTH-1:0] igmp_ff,  igmp_in;
   logic [ipv4f_pkg::COUNT_WIDTH-1:0] other_ff, other_in;
   logic [ipv4f_pkg::COUNT_WIDTH-1:0] total_ff, total_in;
   logic                              accepted_ff, accepted_in;

   always_comb begin
      tcp_in      = tcp_ff   + ipv4f_pkg::COUNT_WIDTH'(verdict.bump_tcp);
      udp_in      = udp_ff   + ipv4f_pkg::COUNT_WIDTH'(verdict.bump_udp);
      icmp_in     = icmp_ff  + ipv4f_pkg::COUNT_WIDTH'(verdict.bump_icmp);
      igmp_in     = igmp_ff  + ipv4f_pkg::COUNT_WIDTH'(verdict.bump_igmp);
      other_in    = other_ff + ipv4f_pkg::COUNT_WIDTH'(verdict.bump_other);
      total_in    = total_ff + ipv4f_pkg::COUNT_WIDTH'(verdict.accept);
      accepted_in = verdict.accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tcp_ff   <= '0;
         udp_ff   <= '0;
         icmp_ff  <= '0;
         igmp_ff  <= '0;
         other_ff <= '0;
         total_ff <= '0;
      end else if (load) begin
         tcp_ff   <= tcp_in;
         udp_ff   <= udp_in;
         icmp_ff  <= icmp_in;
         igmp_ff  <= igmp_in;
         other_ff <= other_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         accepted_ff <= accepted_in;
      end
   end

   assign result.accepted    = accepted_ff;
   assign result.tcp_count   = tcp_ff;
   assign result.udp_count   = udp_ff;
   assign result.icmp_count  = icmp_ff;
   assign result.igmp_count  = igmp_ff;
   assign result.other_count = other_ff;
   assign result.total_count = total_ff;

   // at most one protocol counter steps per item
   a_one_bump: assert property (@(posedge clock) disable iff (reset)
      load |-> $onehot0({verdict.bump_tcp, verdict.bump_udp, verdict.bump_icmp,
                         verdict.bump_igmp, verdict.bump_other}))
      else $error("more than one protocol counter stepped");

   // an accepted item has always stepped exactly one protocol counter
   a_accept_bump: assert property (@(posedge clock) disable iff (reset)
      (load && verdict.accept) |-> $onehot({verdict.bump_tcp, verdict.bump_udp,
                         verdict.bump_icmp, verdict.bump_igmp, verdict.bump_other}))
      else $error("accepted item without a protocol count");

   // total advances by one on an accepted item
   a_total_step: assert property (@(posedge clock) disable iff (reset)
      (load && verdict.accept) |=> (total_ff == $past(total_ff) + 1'b1))
      else $error("total counter did not advance");

   // counters hold while no item moves into the result register
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !load |=> ($stable(total_ff) && $stable(tcp_ff) && $stable(udp_ff)))
      else $error("counter changed without an item");

endmodule

### hdl/ipv4_header_filter_counter_unit.sv
// ----------------------------------------------------------------------------
// IPv4 header filter and protocol counter
// Filters extracted IPv4 header fields and keeps per-protocol and total counts.
// ----------------------------------------------------------------------------
// The block takes one item per cycle, while the result side is not stalling:
// the extracted header fields of one IPv4 packet. Each item gives exactly one
// result, after it passes through the input register and then the result
// register. The filter checks and the six 32-bit counter increments sit in the
// single logic stage between those two registers, so the sustained rate is one
// item per clock without stalls. The result carries the accepted flag and every
// counter value after this packet; counters wrap at 2^32. A TCP or UDP packet
// that clears the address, TTL, fragment and protocol checks steps its protocol
// counter even when a port check then rejects it; the total only steps for
// packets that pass every enabled check. Write configuration only while no
// item is in flight; the write port is always ready and writes to unused
// indexes are dropped.
// ----------------------------------------------------------------------------
module ipv4_header_filter_counter_unit (
   input  logic                                  clock,
   input  logic                                  reset,

   // configuration write port
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ipv4f_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ipv4f_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,

   // header item channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [31:0]                           req_src_addr,
   input  logic [31:0]                           req_dst_addr,
   input  logic [7:0]                            req_time_to_live,
   input  logic [15:0]                           req_frag_word,
   input  logic [7:0]                            req_protocol,
   input  logic [15:0]                           req_src_port,
   input  logic [15:0]                           req_dst_port,

   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_accepted,
   output logic [31:0]                           rsp_tcp_count,
   output logic [31:0]                           rsp_udp_count,
   output logic [31:0]                           rsp_icmp_count,
   output logic [31:0]                           rsp_igmp_count,
   output logic [31:0]                           rsp_other_count,
   output logic [31:0]                           rsp_total_count
);

   ipv4f_pkg::cfg_type     cfg;
   ipv4f_pkg::hdr_type     hdr_ff;
   ipv4f_pkg::hdr_type     hdr_in;
   ipv4f_pkg::verdict_type verdict;
   ipv4f_pkg::result_type  result;

   logic hdr_valid_ff;
   logic rsp_valid_ff;
   logic res_load;
   logic hdr_load;

   // configuration registers: always ready, writes take effect in the next cycle
   assign csr_ready = 1'b1;

   ipv4f_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // advance the result register with a held item when it is empty or taken
   assign res_load = hdr_valid_ff && (!rsp_valid_ff || !rsp_stall);
   // take a new header when the input register is empty or moving on
   assign hdr_load = req_valid && !req_stall;
   assign req_stall = hdr_valid_ff && !res_load;

   always_comb begin
      hdr_in.src_addr     = req_src_addr;
      hdr_in.dst_addr     = req_dst_addr;
      hdr_in.time_to_live = req_time_to_live;
      hdr_in.frag_word    = req_frag_word;
      hdr_in.protocol     = req_protocol;
      hdr_in.src_port     = req_src_port;
      hdr_in.dst_port     = req_dst_port;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // hold the input item until it moves to the result stage
         if (hdr_load) begin
            hdr_valid_ff <= 1'b1;
         end else if (res_load) begin
            hdr_valid_ff <= 1'b0;
         end
         // hold the result until the far side takes it
         if (res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // header payload needs no reset
   always_ff @(posedge clock) begin
      if (hdr_load) begin
         hdr_ff <= hdr_in;
      end
   end

   ipv4f_check u_check (
      .hdr     (hdr_ff),
      .cfg     (cfg),
      .verdict (verdict)
   );

   ipv4f_count u_count (
      .clock   (clock),
      .reset   (reset),
      .load    (res_load),
      .verdict (verdict),
      .result  (result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = result.accepted;
   assign rsp_tcp_count   = result.tcp_count;
   assign rsp_udp_count   = result.udp_count;
   assign rsp_icmp_count  = result.icmp_count;
   assign rsp_igmp_count  = result.igmp_count;
   assign rsp_other_count = result.other_count;
   assign rsp_total_count = result.total_count;

endmodule

### bench/ipv4_header_filter_counter_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 header filter checker
// Watches the register, header and result channels of the filter, keeps its
// own copy of the settings and the six tallies, and compares every result
// with the one it works out for the matching header.
// ----------------------------------------------------------------------------
module ipv4_header_filter_counter_unit_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [ipv4f_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ipv4f_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic [31:0]                           req_src_addr,
   input  logic [31:0]                           req_dst_addr,
   input  logic [7:0]                            req_time_to_live,
   input  logic [15:0]                           req_frag_word,
   input  logic [7:0]                            req_protocol,
   input  logic [15:0]                           req_src_port,
   input  logic [15:0]                           req_dst_port,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic                                  rsp_accepted,
   input  logic [31:0]                           rsp_tcp_count,
   input  logic [31:0]                           rsp_udp_count,
   input  logic [31:0]                           rsp_icmp_count,
   input  logic [31:0]                           rsp_igmp_count,
   input  logic [31:0]                           rsp_other_count,
   input  logic [31:0]                           rsp_total_count,
   output int                                    failures,
   output int                                    outstanding
);
   import ipv4f_pkg::*;

   cfg_type     settings;
   logic [31:0] tcp_tally, udp_tally, icmp_tally, igmp_tally, other_tally, total_tally;
   result_type  counts_due[$];

   function automatic void flag(string msg);
      failures++;
      if (failures <= 10) begin
         $display("%0t ns: %s", $time, msg);
      end
   endfunction

   function automatic void compare_count(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         flag($sformatf("%s: expected %08h, got %08h", name, want, got));
      end
   endfunction

   function automatic void take_setting(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] data);
      case (idx)
         CSR_ENABLE_MASK:     settings.enable_mask     = data[12:0];
         CSR_SRC_ADDR_MATCH:  settings.src_addr_match  = data;
         CSR_DST_ADDR_MATCH:  settings.dst_addr_match  = data;
         CSR_SRC_PORT_MATCH:  settings.src_port_match  = data[15:0];
         CSR_DST_PORT_MATCH:  settings.dst_port_match  = data[15:0];
         CSR_TTL_WINDOW:      settings.ttl_window      = data[15:0];
         CSR_FRAG_LOW_BOUND:  settings.frag_low_bound  = data[15:0];
         CSR_FRAG_HIGH_BOUND: settings.frag_high_bound = data[15:0];
         default: ;
      endcase
   endfunction

   // filter one header, step the tallies and return the counts after it
   function automatic result_type filter_and_count(hdr_type h);
      result_type  r;
      logic        ok;
      logic        ports_ok;
      logic [12:0] m;

      m  = settings.enable_mask;
      ok = 1'b1;
      if (m[EN_SRC_ADDR] && h.src_addr != settings.src_addr_match) ok = 1'b0;
      if (m[EN_DST_ADDR] && h.dst_addr != settings.dst_addr_match) ok = 1'b0;
      if (m[EN_TTL_MIN] && h.time_to_live < settings.ttl_window[7:0]) ok = 1'b0;
      if (m[EN_TTL_MAX] && h.time_to_live > settings.ttl_window[15:8]) ok = 1'b0;
      if (m[EN_FRAG_MIN] && h.frag_word < settings.frag_low_bound) ok = 1'b0;
      if (m[EN_FRAG_MAX] && h.frag_word > settings.frag_high_bound) ok = 1'b0;
      ports_ok = !(m[EN_SRC_PORT] && h.src_port != settings.src_port_match) &&
                 !(m[EN_DST_PORT] && h.dst_port != settings.dst_port_match);

      if (ok) begin
         case (h.protocol)
            PROTO_ICMP: begin
               ok = !m[EN_PROTO] || m[EN_ALLOW_ICMP];
               if (ok) icmp_tally = icmp_tally + 1;
            end
            PROTO_IGMP: begin
               ok = !m[EN_PROTO] || m[EN_ALLOW_IGMP];
               if (ok) igmp_tally = igmp_tally + 1;
            end
            PROTO_TCP: begin
               ok = !m[EN_PROTO] || m[EN_ALLOW_TCP];
               if (ok) begin
                  tcp_tally = tcp_tally + 1;
                  ok = ports_ok;
               end
            end
            PROTO_UDP: begin
               ok = !m[EN_PROTO] || m[EN_ALLOW_UDP];
               if (ok) begin
                  udp_tally = udp_tally + 1;
                  ok = ports_ok;
               end
            end
            default: begin
               ok = !m[EN_PROTO];
               if (ok) other_tally = other_tally + 1;
            end
         endcase
      end
      if (ok) total_tally = total_tally + 1;

      r.accepted    = ok;
      r.tcp_count   = tcp_tally;
      r.udp_count   = udp_tally;
      r.icmp_count  = icmp_tally;
      r.igmp_count  = igmp_tally;
      r.other_count = other_tally;
      r.total_count = total_tally;
      return r;
   endfunction

   always @(posedge clock) begin
      hdr_type    h;
      result_type want;

      if (reset) begin
         settings.enable_mask     = '0;
         settings.src_addr_match  = '0;
         settings.dst_addr_match  = '0;
         settings.src_port_match  = '0;
         settings.dst_port_match  = '0;
         settings.ttl_window      = TTL_WINDOW_RESET;
         settings.frag_low_bound  = '0;
         settings.frag_high_bound = FRAG_HIGH_RESET;
         tcp_tally   = '0;
         udp_tally   = '0;
         icmp_tally  = '0;
         igmp_tally  = '0;
         other_tally = '0;
         total_tally = '0;
         counts_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            take_setting(csr_index, csr_wdata);
         end
         // retire the oldest expectation before adding this edge's header
         if (rsp_valid && !rsp_stall) begin
            if (counts_due.size() == 0) begin
               flag("result arrived with no header outstanding");
            end else begin
               want = counts_due.pop_front();
               compare_count("accepted", 32'(want.accepted), 32'(rsp_accepted));
               compare_count("tcp_count", want.tcp_count, rsp_tcp_count);
               compare_count("udp_count", want.udp_count, rsp_udp_count);
               compare_count("icmp_count", want.icmp_count, rsp_icmp_count);
               compare_count("igmp_count", want.igmp_count, rsp_igmp_count);
               compare_count("other_count", want.other_count, rsp_other_count);
               compare_count("total_count", want.total_count, rsp_total_count);
            end
         end
         if (req_valid && !req_stall) begin
            h.src_addr     = req_src_addr;
            h.dst_addr     = req_dst_addr;
            h.time_to_live = req_time_to_live;
            h.frag_word    = req_frag_word;
            h.protocol     = req_protocol;
            h.src_port     = req_src_port;
            h.dst_port     = req_dst_port;
            counts_due.push_back(filter_and_count(h));
         end
      end
      outstanding = counts_due.size();
   end

endmodule

### bench/ipv4_header_filter_counter_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 header filter testbench
// Drives directed and random packet headers through the filter under several
// register settings, with random idle bursts on the header side and random
// stall bursts on the result side; a checker beside the block compares every
// result and the verdict is given here.
// ----------------------------------------------------------------------------
module ipv4_header_filter_counter_unit_test;
   import ipv4f_pkg::*;

   // generous: about 1450 items, each at worst an idle burst, a stall burst
   // and the pipeline depth, plus register phases
   localparam int CYCLE_LIMIT = 400000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;

   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [31:0]                req_src_addr = '0;
   logic [31:0]                req_dst_addr = '0;
   logic [7:0]                 req_time_to_live = '0;
   logic [15:0]                req_frag_word = '0;
   logic [7:0]                 req_protocol = '0;
   logic [15:0]                req_src_port = '0;
   logic [15:0]                req_dst_port = '0;

   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_accepted;
   logic [31:0]                rsp_tcp_count;
   logic [31:0]                rsp_udp_count;
   logic [31:0]                rsp_icmp_count;
   logic [31:0]                rsp_igmp_count;
   logic [31:0]                rsp_other_count;
   logic [31:0]                rsp_total_count;

   int      failures;
   int      outstanding;
   int      cycles = 0;
   bit      calm = 1'b0;      // set for the closing stretch: no gaps, no stalls
   int      gap_pct = 0;      // chance of an idle burst before an item
   int      stall_pct = 0;    // chance per cycle of starting a stall burst
   int      stall_left = 0;
   cfg_type wr_cfg;           // what was last written, used to aim the headers

   ipv4_header_filter_counter_unit i_dut (.*);

   ipv4_header_filter_counter_unit_checker i_checker (.*);

   always #5 clock = ~clock;

   // Stop a hung run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result side back-pressure: stall in bursts of random length.
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         stall_left = stall_left - 1;
         if (stall_left == 0) rsp_stall <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(1, 17);
      end
   end

   // Pick how busy the idling is for the next stretch: none, light or heavy.
   function automatic int idle_level();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 10;
         default: return 40;
      endcase
   endfunction

   function automatic hdr_type make_header(logic [31:0] sa, logic [31:0] da,
                                           logic [7:0] ttl, logic [15:0] frag,
                                           logic [7:0] proto, logic [15:0] sp,
                                           logic [15:0] dp);
      hdr_type h;
      h.src_addr     = sa;
      h.dst_addr     = da;
      h.time_to_live = ttl;
      h.frag_word    = frag;
      h.protocol     = proto;
      h.src_port     = sp;
      h.dst_port     = dp;
      return h;
   endfunction

   function automatic cfg_type settings_of(logic [12:0] mask, logic [31:0] sa,
                                           logic [31:0] da, logic [15:0] sp,
                                           logic [15:0] dp, logic [15:0] ttlw,
                                           logic [15:0] flo, logic [15:0] fhi);
      cfg_type c;
      c.enable_mask     = mask;
      c.src_addr_match  = sa;
      c.dst_addr_match  = da;
      c.src_port_match  = sp;
      c.dst_port_match  = dp;
      c.ttl_window      = ttlw;
      c.frag_low_bound  = flo;
      c.frag_high_bound = fhi;
      return c;
   endfunction

   // A value on or just beside one of the bounds, or anywhere at all.
   function automatic logic [15:0] near_edge(logic [15:0] lo, logic [15:0] hi);
      case ($urandom_range(0, 7))
         0:       return lo;
         1:       return hi;
         2:       return lo - 16'd1;
         3:       return hi + 16'd1;
         4:       return 16'h0000;
         5:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Bounds: mostly ordered, now and then crossed, sometimes pinned to an end.
   function automatic logic [31:0] random_bounds(int bits);
      logic [15:0] a, b, t;
      logic [15:0] top;

      top = (bits == 8) ? 16'h00FF : 16'hFFFF;
      a = 16'($urandom_range(0, top));
      b = 16'($urandom_range(0, top));
      if ($urandom_range(0, 4) != 0 && a > b) begin
         t = a;
         a = b;
         b = t;
      end
      if ($urandom_range(0, 5) == 0) a = 16'h0000;
      if ($urandom_range(0, 5) == 0) b = top;
      return {b, a};
   endfunction

   function automatic cfg_type random_settings();
      logic [31:0] ttl_b, frag_b;

      ttl_b  = random_bounds(8);
      frag_b = random_bounds(16);
      return settings_of(13'($urandom_range(0, 8191)), $urandom, $urandom,
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         {ttl_b[23:16], ttl_b[7:0]}, frag_b[15:0], frag_b[31:16]);
   endfunction

   // Headers aimed at the current settings so that every check is reached.
   function automatic hdr_type shaped_header();
      hdr_type     h;
      logic [15:0] t;

      h.src_addr  = ($urandom_range(0, 9) < 7) ? wr_cfg.src_addr_match : $urandom;
      h.dst_addr  = ($urandom_range(0, 9) < 7) ? wr_cfg.dst_addr_match : $urandom;
      t = near_edge({8'h00, wr_cfg.ttl_window[7:0]}, {8'h00, wr_cfg.ttl_window[15:8]});
      h.time_to_live = t[7:0];
      h.frag_word = near_edge(wr_cfg.frag_low_bound, wr_cfg.frag_high_bound);
      case ($urandom_range(0, 9))
         0, 1:    h.protocol = PROTO_TCP;
         2, 3:    h.protocol = PROTO_UDP;
         4:       h.protocol = PROTO_ICMP;
         5:       h.protocol = PROTO_IGMP;
         6:       h.protocol = 8'h00;
         7:       h.protocol = 8'hFF;
         default: h.protocol = 8'($urandom_range(0, 255));
      endcase
      h.src_port = ($urandom_range(0, 9) < 6) ? wr_cfg.src_port_match
                                              : 16'($urandom_range(0, 65535));
      h.dst_port = ($urandom_range(0, 9) < 6) ? wr_cfg.dst_port_match
                                              : 16'($urandom_range(0, 65535));
      return h;
   endfunction

   function automatic hdr_type noise_header();
      return make_header($urandom, $urandom, 8'($urandom_range(0, 255)),
                         16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
   endfunction

   // Write one register and hold until the port takes it.
   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Write every register, with junk above each narrower register's width, then poke
   // an unused index, which the block must drop.
   task automatic write_settings(cfg_type c);
      logic [31:0] junk;

      junk = $urandom;
      write_csr(CSR_ENABLE_MASK, {junk[31:13], c.enable_mask});
      write_csr(CSR_SRC_ADDR_MATCH, c.src_addr_match);
      write_csr(CSR_DST_ADDR_MATCH, c.dst_addr_match);
      write_csr(CSR_SRC_PORT_MATCH, {junk[31:16], c.src_port_match});
      write_csr(CSR_DST_PORT_MATCH, {junk[15:0], c.dst_port_match});
      write_csr(CSR_TTL_WINDOW, {junk[23:8], c.ttl_window});
      write_csr(CSR_FRAG_LOW_BOUND, {junk[31:16], c.frag_low_bound});
      write_csr(CSR_FRAG_HIGH_BOUND, {junk[27:12], c.frag_high_bound});
      write_csr(4'($urandom_range(8, 15)), $urandom);
      csr_valid <= 1'b0;
      wr_cfg = c;
   endtask

   // Present one header, maybe after an idle burst, and hold it until taken.
   task automatic send_item(hdr_type h);
      if (!calm && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_src_addr     <= h.src_addr;
      req_dst_addr     <= h.dst_addr;
      req_time_to_live <= h.time_to_live;
      req_frag_word    <= h.frag_word;
      req_protocol     <= h.protocol;
      req_src_port     <= h.src_port;
      req_dst_port     <= h.dst_port;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid, wait for every result, then let the two-stage pipe empty.
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      wr_cfg = settings_of('0, '0, '0, '0, '0, TTL_WINDOW_RESET, '0, FRAG_HIGH_RESET);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: no checks, every packet counts. Field extremes and
      // every protocol class.
      send_item(make_header('0, '0, 8'h00, 16'h0000, 8'h00, 16'h0000, 16'h0000));
      send_item(make_header('1, '1, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF));
      send_item(make_header($urandom, $urandom, 8'd64, 16'h4000, PROTO_TCP, 16'd1234, 16'd80));
      send_item(make_header($urandom, $urandom, 8'd1, 16'h2000, PROTO_UDP, 16'd53, 16'd5353));
      send_item(make_header($urandom, $urandom, 8'd128, 16'h0000, PROTO_ICMP, '0, '0));
      send_item(make_header($urandom, $urandom, 8'd255, 16'h1FFF, PROTO_IGMP, '1, '1));
      settle();

      // Every check on: each rejection path, the port-mismatch counting quirk
      // and the protocol filter throwing out an unlisted protocol.
      write_settings(settings_of(13'h1FFF, 32'hC0A80001, 32'h0A000001, 16'hFFFF,
                                 16'h0000, {8'hC0, 8'h40}, 16'h0100, 16'h7FFF));
      send_item(make_header(32'hC0A80001, 32'h0A000001, 8'h40, 16'h0100, PROTO_TCP,
                            16'hFFFF, 16'h0000));
      send_item(make_header(32'hC0A80001, 32'h0A000001, 8'hC0, 16'h7FFF, PROTO_UDP,
                            16'hFFFF, 16'h0000));
      send_item(make_header(32'hC0A80001, 32'h0A000001, 8'h80, 16'h4000, PROTO_ICMP,
                            16'h1111, 16'h2222));
      send_item(make_header(32'hC0A80001, 32'h0A000001, 8'h80, 16'h4000, PROTO_IGMP,
                            16'h3333, 16'h4444));
      send_item(make_header(32'hC0A80001, 32'h0A000001, 8'h80, 16'h4000, PROTO_TCP,
                            16'hFFFF, 16'h0001));
      send_item(make_header(32'hC0A80001, 32'h0A000001, 8'h80, 16'h4000, PROTO_UDP,
                            16'h0000, 16'h0000));
      send_item(make_header(32'hC0A80001, 32'h0A000001, 8'h80, 16'h4000, 8'd99,
                            16'hFFFF, 16'h0000));
      send_item(make_header(32'hC0A80002, 32'h0A000001, 8'h80, 16'h4000, PROTO_TCP,
                            16'hFFFF, 16'h0000));
      send_item(make_header(32'hC0A80001, 32'h8A000001, 8'h80, 16'h4000, PROTO_TCP,
                            16'hFFFF, 16'h0000));
      send_item(make_header(32'hC0A80001, 32'h0A000001, 8'h3F, 16'h4000, PROTO_TCP,
                            16'hFFFF, 16'h0000));
      send_item(make_header(32'hC0A80001, 32'h0A000001, 8'hC1, 16'h4000, PROTO_TCP,
                            16'hFFFF, 16'h0000));
      send_item(make_header(32'hC0A80001, 32'h0A000001, 8'h80, 16'h00FF, PROTO_UDP,
                            16'hFFFF, 16'h0000));
      send_item(make_header(32'hC0A80001, 32'h0A000001, 8'h80, 16'h8000, PROTO_UDP,
                            16'hFFFF, 16'h0000));
      settle();

      // Crossed TTL and fragment bounds: nothing may pass.
      write_settings(settings_of(13'((1 << EN_TTL_MIN) | (1 << EN_TTL_MAX) |
                                     (1 << EN_FRAG_MIN) | (1 << EN_FRAG_MAX)),
                                 '0, '0, '0, '0, {8'h10, 8'h90}, 16'h8000, 16'h0100));
      send_item(make_header($urandom, $urandom, 8'h50, 16'h4000, PROTO_TCP, '0, '0));
      send_item(make_header($urandom, $urandom, 8'h10, 16'h0100, PROTO_ICMP, '0, '0));
      send_item(make_header($urandom, $urandom, 8'h90, 16'h8000, 8'd47, '0, '0));
      send_item(make_header($urandom, $urandom, 8'h00, 16'h0000, PROTO_UDP, '0, '0));

      // Random phases: the extreme settings first, then random ones. The
      // last phase runs flat out.
      for (int p = 0; p < 12; p++) begin
         settle();
         case (p)
            0: write_settings(settings_of(13'h1FFF, '1, '1, '1, '1, 16'hFFFF, 16'hFFFF,
                                          16'hFFFF));
            1: write_settings(settings_of(13'h1FFF, '0, '0, '0, '0, 16'h0000, 16'h0000,
                                          16'h0000));
            2: write_settings(settings_of(13'(1 << EN_PROTO), $urandom, $urandom,
                                          16'($urandom_range(0, 65535)),
                                          16'($urandom_range(0, 65535)),
                                          16'h00FF, 16'hFFFF, 16'h0000));
            default: write_settings(random_settings());
         endcase
         calm = (p == 11);
         for (int n = 0; n < 120; n++) begin
            if (n % 40 == 0) begin
               gap_pct   = calm ? 0 : idle_level();
               stall_pct = calm ? 0 : idle_level();
            end
            if ($urandom_range(0, 6) == 0) begin
               send_item(noise_header());
            end else begin
               send_item(shaped_header());
            end
         end
      end

      // Drain and give the verdict.
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
